@@ sv/soc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the shape overlap test pipeline.
// Used by every stage module and by the top level; depends on nothing.
package soc_pkg;

   localparam logic [2:0] FUNC_RECT_RECT   = 3'd0;
   localparam logic [2:0] FUNC_CIRC_CIRC   = 3'd1;
   localparam logic [2:0] FUNC_CIRC_RECT   = 3'd2;
   localparam logic [2:0] FUNC_RECT_POINT  = 3'd3;
   localparam logic [2:0] FUNC_CIRC_POINT  = 3'd4;

   // How the final stage forms the hit bit.
   typedef enum logic [1:0] {
      MODE_DIRECT  = 2'd0,
      MODE_CENTER  = 2'd1,
      MODE_CORNERS = 2'd2
   } mode_type;

   typedef struct packed {
      mode_type mode;
      logic     direct_hit;
      logic     rad_neg;
      logic     bad;
   } ctl_type;

endpackage

@@ sv/soc_front.sv @@
`timescale 1ns / 1ps
// First stage: bound compares, coordinate differences and the radius.
// Depends on soc_pkg.
module soc_front import soc_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [2:0]                    func,
   input  logic signed [COORD_WIDTH-1:0] a_x0,
   input  logic signed [COORD_WIDTH-1:0] a_y0,
   input  logic signed [COORD_WIDTH-1:0] a_x1,
   input  logic signed [COORD_WIDTH-1:0] a_y1,
   input  logic signed [COORD_WIDTH-1:0] b_x0,
   input  logic signed [COORD_WIDTH-1:0] b_y0,
   input  logic signed [COORD_WIDTH-1:0] b_x1,
   input  logic signed [COORD_WIDTH-1:0] b_y1,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ctl_type                       out_ctl,
   output logic [COORD_WIDTH:0]          out_dx_l,
   output logic [COORD_WIDTH:0]          out_dx_r,
   output logic [COORD_WIDTH:0]          out_dy_t,
   output logic [COORD_WIDTH:0]          out_dy_b,
   output logic [COORD_WIDTH:0]          out_rad
);

   localparam int EW = COORD_WIDTH + 1;

   function automatic logic [EW-1:0] mag(input logic signed [EW-1:0] d);
      mag = d[EW-1] ? (~d + EW'(1)) : d;
   endfunction

   logic signed [EW-1:0] ax0_e, ay0_e, ax1_e, bx0_e, by0_e, bx1_e, by1_e;
   logic signed [EW-1:0] left_w, right_w, top_w, bottom_w, rad_sum;
   logic                 rect_rect_hit, rect_point_hit, in_span, widened_hit;
   ctl_type              ctl_in, ctl_ff;
   logic                 valid_ff, valid_in;
   logic [EW-1:0]        dx_l_ff, dx_r_ff, dy_t_ff, dy_b_ff, rad_ff;

   always_comb begin
      ax0_e = EW'(a_x0);
      ay0_e = EW'(a_y0);
      ax1_e = EW'(a_x1);
      bx0_e = EW'(b_x0);
      by0_e = EW'(b_y0);
      bx1_e = EW'(b_x1);
      by1_e = EW'(b_y1);

      rect_rect_hit  = !(a_x0 > b_x1) && !(a_x1 < b_x0) && !(a_y0 > b_y1) && !(a_y1 < b_y0);
      rect_point_hit = !(a_x0 > b_x0) && !(a_x1 < b_x0) && !(a_y0 > b_y0) && !(a_y1 < b_y0);

      in_span = (b_x0 <= a_x0 && a_x0 <= b_x1) || (b_y0 <= a_y0 && a_y0 <= b_y1);
      left_w   = bx0_e - ax1_e;
      right_w  = bx1_e + ax1_e;
      top_w    = by0_e - ax1_e;
      bottom_w = by1_e + ax1_e;
      widened_hit = (left_w <= ax0_e) && (ax0_e <= right_w) &&
                    (top_w <= ay0_e) && (ay0_e <= bottom_w);

      rad_sum = (func == FUNC_CIRC_CIRC) ? (ax1_e + bx1_e) : ax1_e;

      ctl_in.mode       = MODE_DIRECT;
      ctl_in.direct_hit = 1'b0;
      ctl_in.rad_neg    = rad_sum[EW-1];
      ctl_in.bad        = 1'b0;
      unique case (func)
         FUNC_RECT_RECT: begin
            ctl_in.direct_hit = rect_rect_hit;
         end
         FUNC_RECT_POINT: begin
            ctl_in.direct_hit = rect_point_hit;
         end
         FUNC_CIRC_CIRC, FUNC_CIRC_POINT: begin
            ctl_in.mode = MODE_CENTER;
         end
         FUNC_CIRC_RECT: begin
            if (in_span) begin
               ctl_in.direct_hit = widened_hit;
            end else begin
               ctl_in.mode = MODE_CORNERS;
            end
         end
         default: begin
            ctl_in.bad = 1'b1;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctl_ff  <= ctl_in;
         dx_l_ff <= mag(ax0_e - bx0_e);
         dx_r_ff <= mag(ax0_e - bx1_e);
         dy_t_ff <= mag(ay0_e - by0_e);
         dy_b_ff <= mag(ay0_e - by1_e);
         rad_ff  <= rad_sum;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_dx_l  = dx_l_ff;
   assign out_dx_r  = dx_r_ff;
   assign out_dy_t  = dy_t_ff;
   assign out_dy_b  = dy_b_ff;
   assign out_rad   = rad_ff;

endmodule

@@ sv/soc_square.sv @@
`timescale 1ns / 1ps
// Second stage: five squaring multipliers for distances and radius.
// Depends on soc_pkg.
module soc_square import soc_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  ctl_type                    in_ctl,
   input  logic [COORD_WIDTH:0]       in_dx_l,
   input  logic [COORD_WIDTH:0]       in_dx_r,
   input  logic [COORD_WIDTH:0]       in_dy_t,
   input  logic [COORD_WIDTH:0]       in_dy_b,
   input  logic [COORD_WIDTH:0]       in_rad,
   output logic                       out_valid,
   input  logic                       out_ready,
   output ctl_type                    out_ctl,
   output logic [2*COORD_WIDTH+1:0]   out_sx_l,
   output logic [2*COORD_WIDTH+1:0]   out_sx_r,
   output logic [2*COORD_WIDTH+1:0]   out_sy_t,
   output logic [2*COORD_WIDTH+1:0]   out_sy_b,
   output logic [2*COORD_WIDTH+1:0]   out_rr
);

   localparam int SW = 2 * COORD_WIDTH + 2;

   logic          valid_ff, valid_in;
   ctl_type       ctl_ff;
   logic [SW-1:0] sx_l_ff, sx_r_ff, sy_t_ff, sy_b_ff, rr_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         ctl_ff  <= in_ctl;
         sx_l_ff <= SW'(in_dx_l) * SW'(in_dx_l);
         sx_r_ff <= SW'(in_dx_r) * SW'(in_dx_r);
         sy_t_ff <= SW'(in_dy_t) * SW'(in_dy_t);
         sy_b_ff <= SW'(in_dy_b) * SW'(in_dy_b);
         rr_ff   <= SW'(in_rad) * SW'(in_rad);
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_sx_l  = sx_l_ff;
   assign out_sx_r  = sx_r_ff;
   assign out_sy_t  = sy_t_ff;
   assign out_sy_b  = sy_b_ff;
   assign out_rr    = rr_ff;

endmodule

@@ sv/soc_decide.sv @@
`timescale 1ns / 1ps
// Third stage: squared distance sums, radius compares and the result register.
// Depends on soc_pkg.
module soc_decide import soc_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  ctl_type                    in_ctl,
   input  logic [2*COORD_WIDTH+1:0]   in_sx_l,
   input  logic [2*COORD_WIDTH+1:0]   in_sx_r,
   input  logic [2*COORD_WIDTH+1:0]   in_sy_t,
   input  logic [2*COORD_WIDTH+1:0]   in_sy_b,
   input  logic [2*COORD_WIDTH+1:0]   in_rr,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic                       out_hit,
   output logic                       out_bad
);

   localparam int TW = 2 * COORD_WIDTH + 3;

   logic [TW-1:0] sum_lt, sum_rt, sum_lb, sum_rb, rr_e;
   logic          hit_in, hit_ff, bad_ff;
   logic          valid_ff, valid_in;

   always_comb begin
      rr_e   = TW'(in_rr);
      sum_lt = TW'(in_sx_l) + TW'(in_sy_t);
      sum_rt = TW'(in_sx_r) + TW'(in_sy_t);
      sum_lb = TW'(in_sx_l) + TW'(in_sy_b);
      sum_rb = TW'(in_sx_r) + TW'(in_sy_b);
      hit_in = 1'b0;
      unique case (in_ctl.mode)
         MODE_DIRECT: begin
            hit_in = in_ctl.direct_hit;
         end
         MODE_CENTER: begin
            hit_in = !in_ctl.rad_neg && (sum_lt <= rr_e);
         end
         MODE_CORNERS: begin
            hit_in = !in_ctl.rad_neg && ((sum_lt <= rr_e) || (sum_rt <= rr_e) ||
                                         (sum_lb <= rr_e) || (sum_rb <= rr_e));
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         hit_ff <= hit_in && !in_ctl.bad;
         bad_ff <= in_ctl.bad;
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;
   assign out_bad   = bad_ff;

endmodule

@@ sv/shape_overlap_test_core.sv @@
`timescale 1ns / 1ps
// Top level of the shape overlap test: three pipeline stages in a row.
// Depends on soc_pkg, soc_front, soc_square and soc_decide.
//
// Each request beat carries an operation code and two shapes in signed fixed
// point (Q12.4 at the default width); each response beat carries hit and
// bad_func for exactly one request, in request order.
// Stage one compares bounds and forms coordinate differences, stage two
// squares them with five multipliers, and stage three adds the squares,
// compares against the squared radius and holds the response.
// An accepted request is registered in turn by stages one, two and three,
// and rsp_valid rises once it is held in the stage-three register.
// Throughput is one beat per cycle; a new request is taken every cycle
// while the response side keeps up.
// When the receiver stalls, each stage holds its beat and an empty stage
// still takes one, so bubbles close up; req_ready falls only once all
// three stages are full.
// Reset empties all stages; no beat is in flight afterward.
module shape_overlap_test_core import soc_pkg::*; #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_func,
   input  logic signed [COORD_WIDTH-1:0] req_a_x0,
   input  logic signed [COORD_WIDTH-1:0] req_a_y0,
   input  logic signed [COORD_WIDTH-1:0] req_a_x1,
   input  logic signed [COORD_WIDTH-1:0] req_a_y1,
   input  logic signed [COORD_WIDTH-1:0] req_b_x0,
   input  logic signed [COORD_WIDTH-1:0] req_b_y0,
   input  logic signed [COORD_WIDTH-1:0] req_b_x1,
   input  logic signed [COORD_WIDTH-1:0] req_b_y1,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic                          rsp_bad_func
);

   logic                       s1_valid, s1_ready, s2_valid, s2_ready;
   ctl_type                    s1_ctl, s2_ctl;
   logic [COORD_WIDTH:0]       s1_dx_l, s1_dx_r, s1_dy_t, s1_dy_b, s1_rad;
   logic [2*COORD_WIDTH+1:0]   s2_sx_l, s2_sx_r, s2_sy_t, s2_sy_b, s2_rr;

   soc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .func      (req_func),
      .a_x0      (req_a_x0),
      .a_y0      (req_a_y0),
      .a_x1      (req_a_x1),
      .a_y1      (req_a_y1),
      .b_x0      (req_b_x0),
      .b_y0      (req_b_y0),
      .b_x1      (req_b_x1),
      .b_y1      (req_b_y1),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_ctl   (s1_ctl),
      .out_dx_l  (s1_dx_l),
      .out_dx_r  (s1_dx_r),
      .out_dy_t  (s1_dy_t),
      .out_dy_b  (s1_dy_b),
      .out_rad   (s1_rad)
   );

   soc_square #(.COORD_WIDTH(COORD_WIDTH)) u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_ctl    (s1_ctl),
      .in_dx_l   (s1_dx_l),
      .in_dx_r   (s1_dx_r),
      .in_dy_t   (s1_dy_t),
      .in_dy_b   (s1_dy_b),
      .in_rad    (s1_rad),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_ctl   (s2_ctl),
      .out_sx_l  (s2_sx_l),
      .out_sx_r  (s2_sx_r),
      .out_sy_t  (s2_sy_t),
      .out_sy_b  (s2_sy_b),
      .out_rr    (s2_rr)
   );

   soc_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_ctl    (s2_ctl),
      .in_sx_l   (s2_sx_l),
      .in_sx_r   (s2_sx_r),
      .in_sy_t   (s2_sy_t),
      .in_sy_b   (s2_sy_b),
      .in_rr     (s2_rr),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_hit   (rsp_hit),
      .out_bad   (rsp_bad_func)
   );

   // An invalid code must never report a hit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_bad_func))
      else $error("bad_func beat reports a hit");

   // With the last stage empty the whole pipeline can take a beat.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty response stage");

   // A receiver that takes the response never blocks the request side.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while response side is ready");

   // Reset leaves no beat in flight.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !s1_valid && !s2_valid)
      else $error("pipeline not empty after reset");

endmodule
